>>> src/cst_pkg.sv
// Shared constants, codes and handshake structs for the client session table.
package cst_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_CHARS     = 8;

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int MODE_W    = 2;
    localparam int KEY_W     = 64;
    localparam int KIND_W    = 3;
    localparam int HANDLE_W  = 16;
    localparam int ADDR_W    = 32;
    localparam int PORT_W    = 16;
    localparam int TIME_W    = 48;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int CLIENTS_W = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_UPDATE = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
    } dp_stat_t;

endpackage

>>> src/cst_ctrl.sv
// Sequencer for the client session table: accept, scan, commit, output handshake.
module cst_ctrl
    import cst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // result register must be empty or emptying this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> src/cst_datapath.sv
// Table storage, key folding, slot scan and result registers.
module cst_datapath
    import cst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [MODE_W-1:0]    mode,
    input  logic [KEY_W-1:0]     key_text,
    input  logic [KIND_W-1:0]    link_kind,
    input  logic [HANDLE_W-1:0]  link_handle,
    input  logic [ADDR_W-1:0]    net_address,
    input  logic [PORT_W-1:0]    net_port,
    input  logic [TIME_W-1:0]    now_time,
    output logic [STATUS_W-1:0]  status,
    output logic [SLOT_W-1:0]    slot_index,
    output logic [CLIENTS_W-1:0] client_count,
    output logic [KIND_W-1:0]    found_kind,
    output logic [HANDLE_W-1:0]  found_handle,
    output logic [ADDR_W-1:0]    found_address,
    output logic [PORT_W-1:0]    found_port,
    output logic [TIME_W-1:0]    found_time
);

    // Name ends at first zero byte; lower-case letters folded up.
    function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] res;
        logic             ended;
        logic [7:0]       c;
        res   = '0;
        ended = 1'b0;
        for (int i = 0; i < KEY_CHARS; i++)
        begin
            c = raw[8*i +: 8];
            if (c == 8'h00)
            begin
                ended = 1'b1;
            end
            if (!ended)
            begin
                if (c >= 8'h61 && c <= 8'h7A)
                begin
                    c = c - 8'h20;
                end
                res[8*i +: 8] = c;
            end
        end
        return res;
    endfunction

    // command latch
    mode_t               mode_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [PORT_W-1:0]   port_reg;
    logic [TIME_W-1:0]   time_reg;

    // table; only kind carries occupancy and needs clearing
    logic [KIND_W-1:0]   entry_kind_reg    [TABLE_ENTRIES];
    logic [KEY_W-1:0]    entry_key_reg     [TABLE_ENTRIES];
    logic [HANDLE_W-1:0] entry_handle_reg  [TABLE_ENTRIES];
    logic [ADDR_W-1:0]   entry_address_reg [TABLE_ENTRIES];
    logic [PORT_W-1:0]   entry_port_reg    [TABLE_ENTRIES];
    logic [TIME_W-1:0]   entry_time_reg    [TABLE_ENTRIES];
    logic [COUNT_W-1:0]  count_reg;

    // scan state
    logic [IDX_W-1:0]    idx_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic                free_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [KIND_W-1:0]   hit_kind_reg;
    logic [HANDLE_W-1:0] hit_handle_reg;
    logic [ADDR_W-1:0]   hit_addr_reg;
    logic [PORT_W-1:0]   hit_port_reg;
    logic [TIME_W-1:0]   hit_time_reg;

    // result registers
    status_t             status_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [KIND_W-1:0]   res_kind_reg;
    logic [HANDLE_W-1:0] res_handle_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    logic [PORT_W-1:0]   res_port_reg;
    logic [TIME_W-1:0]   res_time_reg;

    logic                entry_hit;
    logic                entry_free;

    logic                wr_fields;
    logic                wr_key;
    logic                rm_entry;
    logic                clr_all;
    logic                found_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [COUNT_W-1:0]  count_next;
    status_t             status_next;
    logic [IDX_W-1:0]    slot_next;

    assign entry_free = (entry_kind_reg[idx_reg] == '0);
    assign entry_hit  = !entry_free && (entry_key_reg[idx_reg] == key_reg);
    assign stat.scan_last = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode_t'(mode);
            key_reg    <= fold_key(key_text);
            kind_reg   <= link_kind;
            handle_reg <= link_handle;
            addr_reg   <= net_address;
            port_reg   <= net_port;
            time_reg   <= now_time;
        end
        if (cmd.step)
        begin
            if (entry_hit && !hit_reg)
            begin
                hit_idx_reg    <= idx_reg;
                hit_kind_reg   <= entry_kind_reg[idx_reg];
                hit_handle_reg <= entry_handle_reg[idx_reg];
                hit_addr_reg   <= entry_address_reg[idx_reg];
                hit_port_reg   <= entry_port_reg[idx_reg];
                hit_time_reg   <= entry_time_reg[idx_reg];
            end
            if (entry_free && !free_reg)
            begin
                free_idx_reg <= idx_reg;
            end
        end
        if (cmd.commit)
        begin
            status_reg     <= status_next;
            slot_reg       <= slot_next;
            res_kind_reg   <= found_en ? hit_kind_reg   : '0;
            res_handle_reg <= found_en ? hit_handle_reg : '0;
            res_addr_reg   <= found_en ? hit_addr_reg   : '0;
            res_port_reg   <= found_en ? hit_port_reg   : '0;
            res_time_reg   <= found_en ? hit_time_reg   : '0;
            if (wr_fields)
            begin
                entry_handle_reg[wr_idx]  <= handle_reg;
                entry_address_reg[wr_idx] <= addr_reg;
                entry_port_reg[wr_idx]    <= port_reg;
                entry_time_reg[wr_idx]    <= time_reg;
            end
            if (wr_key)
            begin
                entry_key_reg[wr_idx] <= key_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            count_reg <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                entry_kind_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg  <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (entry_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (entry_free)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                count_reg <= count_next;
                if (clr_all)
                begin
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        entry_kind_reg[i] <= '0;
                    end
                end
                else if (rm_entry)
                begin
                    entry_kind_reg[hit_idx_reg] <= '0;
                end
                else if (wr_fields)
                begin
                    entry_kind_reg[wr_idx] <= kind_reg;
                end
            end
        end
    end

    // commit decision from the scan outcome
    always_comb
    begin
        wr_fields   = 1'b0;
        wr_key      = 1'b0;
        rm_entry    = 1'b0;
        clr_all     = 1'b0;
        found_en    = 1'b0;
        wr_idx      = hit_idx_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        slot_next   = '0;
        unique case (mode_reg)
            MODE_UPDATE:
            begin
                if (kind_reg == '0)
                begin
                    status_next = ST_UNKNOWN;
                end
                else if (hit_reg)
                begin
                    wr_fields = 1'b1;
                    slot_next = hit_idx_reg;
                end
                else if (count_reg < COUNT_W'(TABLE_ENTRIES) && free_reg)
                begin
                    wr_fields  = 1'b1;
                    wr_key     = 1'b1;
                    wr_idx     = free_idx_reg;
                    slot_next  = free_idx_reg;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            MODE_REMOVE:
            begin
                if (count_reg != '0)
                begin
                    if (hit_reg)
                    begin
                        rm_entry   = 1'b1;
                        slot_next  = hit_idx_reg;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        status_next = ST_UNKNOWN;
                    end
                end
            end
            MODE_LOOKUP:
            begin
                if (count_reg != '0 && hit_reg)
                begin
                    found_en  = 1'b1;
                    slot_next = hit_idx_reg;
                end
                else
                begin
                    status_next = ST_UNKNOWN;
                end
            end
            MODE_CLEAR:
            begin
                clr_all    = 1'b1;
                count_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign status        = status_reg;
    assign slot_index    = SLOT_W'(slot_reg);
    assign client_count  = CLIENTS_W'(count_reg);
    assign found_kind    = res_kind_reg;
    assign found_handle  = res_handle_reg;
    assign found_address = res_addr_reg;
    assign found_port    = res_port_reg;
    assign found_time    = res_time_reg;

endmodule

>>> src/client_session_table_unit.sv
// Top level of the client session table: controller plus table datapath.
//
// Usage: a command transfer on the input channel (in_valid/in_ready) carries
// mode, key_text and the link fields; one result transfer follows on the
// output channel (out_valid/out_ready) with status, slot_index, client_count
// and, for a lookup, the stored fields of the matching slot.
// Sequence: the accepting edge latches and folds the key, then the scan
// checks one table slot per cycle over all TABLE_ENTRIES = 16 slots, then the
// commit writes the table and loads the result register, raising out_valid.
// A new command is not taken while one is in flight; the next command is
// taken the cycle after commit.
// A result left waiting in the output register does not block the next
// command; only its commit waits until the result register has been taken.
// Reset: every slot is free, the count is zero, out_valid is low and in_ready
// is high.
// Clear empties the table in the commit cycle; no sweep is needed since
// occupancy lives in per-slot flops.
module client_session_table_unit
    import cst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [MODE_W-1:0]    mode,
    input  logic [KEY_W-1:0]     key_text,
    input  logic [KIND_W-1:0]    link_kind,
    input  logic [HANDLE_W-1:0]  link_handle,
    input  logic [ADDR_W-1:0]    net_address,
    input  logic [PORT_W-1:0]    net_port,
    input  logic [TIME_W-1:0]    now_time,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [SLOT_W-1:0]    slot_index,
    output logic [CLIENTS_W-1:0] client_count,
    output logic [KIND_W-1:0]    found_kind,
    output logic [HANDLE_W-1:0]  found_handle,
    output logic [ADDR_W-1:0]    found_address,
    output logic [PORT_W-1:0]    found_port,
    output logic [TIME_W-1:0]    found_time
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: load on input transfer, scan, commit when output is free
    cst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // table, key fold, first-hit / first-free scan and result registers
    cst_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .key_text      (key_text),
        .link_kind     (link_kind),
        .link_handle   (link_handle),
        .net_address   (net_address),
        .net_port      (net_port),
        .now_time      (now_time),
        .status        (status),
        .slot_index    (slot_index),
        .client_count  (client_count),
        .found_kind    (found_kind),
        .found_handle  (found_handle),
        .found_address (found_address),
        .found_port    (found_port),
        .found_time    (found_time)
    );

endmodule
